// ===== hw/rtl/fbtr_pkg.sv =====
// ----------------------------------------------------------------------------
// fbtr_pkg
// Shared types, command codes and the 5x7 glyph table for the frame buffer
// text renderer.
// ----------------------------------------------------------------------------
package fbtr_pkg;

  // Command codes carried by the command field of a request.
  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_SET   = 3'd1,
    CMD_UNSET = 3'd2,
    CMD_GLYPH = 3'd3,
    CMD_FILL  = 3'd4,
    CMD_READ  = 3'd5
  } cmd_code_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_item;
    logic sweep_write;
    logic rmw_read;
    logic rmw_write;
    logic walk_step;
    logic result_load;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic in_clear;
    logic skip;
    logic walk_last;
    logic sweep_last;
    logic out_full;
  } dp_status_t;

  localparam int GLYPH_COUNT = 37;
  localparam int GLYPH_COLS  = 5;

  // Code ranges that have a glyph; slot 0 is the blank glyph.
  localparam logic [7:0] CODE_DIGIT_LO = 8'h30;
  localparam logic [7:0] CODE_DIGIT_HI = 8'h39;
  localparam logic [7:0] CODE_UPPER_LO = 8'h41;
  localparam logic [7:0] CODE_UPPER_HI = 8'h5A;
  localparam logic [5:0] SLOT_DIGIT    = 6'd1;
  localparam logic [5:0] SLOT_UPPER    = 6'd11;

  // Glyph columns, bit 0 is the top row.
  localparam logic [7:0] GLYPH_ROM [GLYPH_COUNT][GLYPH_COLS] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E}, '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
    '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46}, '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10}, '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30}, '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36}, '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E},
    '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  // Map a character code to its glyph slot; unknown codes use the blank glyph.
  function automatic logic [5:0] glyph_slot(input logic [7:0] code);
    logic [5:0] slot;
    slot = '0;
    if (code >= CODE_DIGIT_LO && code <= CODE_DIGIT_HI) begin
      slot = SLOT_DIGIT + 6'(code - CODE_DIGIT_LO);
    end else if (code >= CODE_UPPER_LO && code <= CODE_UPPER_HI) begin
      slot = SLOT_UPPER + 6'(code - CODE_UPPER_LO);
    end
    return slot;
  endfunction

endpackage

// ===== hw/rtl/framebuffer_text_renderer.sv =====
// ----------------------------------------------------------------------------
// framebuffer_text_renderer
// Monochrome page-format frame store with pixel, 5x7 text, rectangle fill,
// clear and byte read commands.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on in_valid_i/in_stall_o with the command and its operand
// fields; each request yields exactly one result on out_valid_o/out_stall_i
// carrying read_data_o (the addressed byte for a read, zero otherwise).
// Requests are handled one at a time through a single-port frame memory;
// pixel, glyph and fill read-modify-write each byte. Bytes touched:
//   set/clear pixel and read:  the one addressed byte,
//   glyph:                     5 columns by 2 pages,
//   fill:                      every covered byte,
//   clear:                     all SCREEN_WIDTH*PAGE_COUNT bytes, by a write sweep,
//   unused codes, empty fill:  none.
// A new request can be taken in the cycle after the previous result is
// loaded, even while that result is still stalled in the output register;
// a finished request waits only while the output register holds a stalled
// result. After reset the block clears all SCREEN_WIDTH*PAGE_COUNT bytes
// of the store (1024 by default) one byte per cycle, with in_stall_o high.
// ----------------------------------------------------------------------------
module framebuffer_text_renderer #(
  parameter int SCREEN_WIDTH = 128,
  parameter int PAGE_COUNT   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [7:0] x_start_i,
  input  logic [7:0] y_start_i,
  input  logic [7:0] x_end_i,
  input  logic [7:0] y_end_i,
  input  logic [7:0] char_code_i,
  input  logic [9:0] read_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);
  import fbtr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // Sequencer.
  fbtr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // Frame store and byte datapath.
  fbtr_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .PAGE_COUNT   (PAGE_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .command_i    (command_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .char_code_i  (char_code_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .cmd_i        (cmd),
    .st_o         (st)
  );

  // One request in flight: intake closes right after a request is taken.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while another is in progress");

  // The memory port serves one purpose per cycle.
  a_mem_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.sweep_write, cmd.rmw_read, cmd.rmw_write}))
    else $error("frame memory port used twice in one cycle");

  // A loaded result is presented in the next cycle.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result_load |=> out_valid_o)
    else $error("loaded result not presented");

  // A result is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result_load |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

endmodule

// ===== hw/rtl/fbtr_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbtr_ctrl
// Sequencer for the renderer: reset clearing pass, request intake, clear
// sweep, byte read-modify-write walk and result hand-off.
// ----------------------------------------------------------------------------
module fbtr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  fbtr_pkg::dp_status_t   st_i,
  output fbtr_pkg::ctrl_cmd_t    cmd_o
);
  import fbtr_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CLEAR = 6'b000100,
    S_READ  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_write = 1'b1;
        if (st_i.sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = st_i.in_clear ? S_CLEAR : S_READ;
        end
      end
      S_CLEAR: begin
        cmd_o.sweep_write = 1'b1;
        if (st_i.sweep_last) state_d = S_DONE;
      end
      S_READ: begin
        if (st_i.skip) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rmw_read = 1'b1;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.rmw_write = 1'b1;
        if (st_i.walk_last) begin
          state_d = S_DONE;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (!st_i.out_full) begin
          cmd_o.result_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/fbtr_datapath.sv =====
// ----------------------------------------------------------------------------
// fbtr_datapath
// Frame store memory, request registers, byte walk cursors, mask and
// address generation, and the output register.
// ----------------------------------------------------------------------------
module fbtr_datapath #(
  parameter int SCREEN_WIDTH = 128,
  parameter int PAGE_COUNT   = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [2:0]             command_i,
  input  logic [7:0]             x_start_i,
  input  logic [7:0]             y_start_i,
  input  logic [7:0]             x_end_i,
  input  logic [7:0]             y_end_i,
  input  logic [7:0]             char_code_i,
  input  logic [9:0]             read_index_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [7:0]             read_data_o,
  input  fbtr_pkg::ctrl_cmd_t    cmd_i,
  output fbtr_pkg::dp_status_t   st_o
);
  import fbtr_pkg::*;

  localparam int         STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int         AW          = $clog2(STORE_BYTES);
  localparam logic [7:0] X_MAX       = 8'(SCREEN_WIDTH - 1);
  localparam logic [7:0] Y_MAX       = 8'(PAGE_COUNT * 8 - 1);

  // Request registers.
  cmd_code_e   cmd_q;
  logic [7:0]  x_start_q, y_start_q, x_end_q, y_end_q;
  logic [5:0]  slot_q;
  logic [9:0]  read_index_q;

  // Walk cursors, sweep cursor, memory and result registers.
  logic [8:0]    col_q;
  logic [5:0]    page_q;
  logic [AW-1:0] sweep_q;
  logic [7:0]    mem_q [STORE_BYTES];
  logic [7:0]    rdata_q;
  logic [7:0]    acc_q;
  logic          out_valid_q;
  logic [7:0]    read_data_q;

  // Walk limits and per-byte values.
  logic [7:0]    x_last, y_last;
  logic          fill_empty;
  logic [8:0]    col_last;
  logic [5:0]    page_first, page_last;
  logic          at_page_first, at_page_last, walk_last;
  logic [2:0]    gcol, lo, hi;
  logic [15:0]   gshift;
  logic [7:0]    mask, new_byte;
  logic          byte_ok, mem_we;
  logic [AW-1:0] walk_addr, mem_addr;

  // Rectangle clipping to the screen.
  assign x_last     = (x_end_q > X_MAX) ? X_MAX : x_end_q;
  assign y_last     = (y_end_q > Y_MAX) ? Y_MAX : y_end_q;
  assign fill_empty = (x_start_q > x_last) || (y_start_q > y_last);
  assign page_first = 6'(y_start_q[7:3]);

  // Last column and page of the walk for each command.
  always_comb begin
    col_last  = {1'b0, x_start_q};
    page_last = page_first;
    unique case (cmd_q)
      CMD_GLYPH: begin
        col_last  = {1'b0, x_start_q} + 9'(GLYPH_COLS - 1);
        page_last = page_first + 6'd1;
      end
      CMD_FILL: begin
        col_last  = {1'b0, x_last};
        page_last = 6'(y_last[7:3]);
      end
      default: ;
    endcase
  end

  assign at_page_first = (page_q == page_first);
  assign at_page_last  = (page_q == page_last);
  assign walk_last     = (cmd_q == CMD_READ) || ((col_q == col_last) && at_page_last);

  // Glyph column shifted to the row offset; upper half lands in the next page.
  assign gcol   = 3'(col_q - {1'b0, x_start_q});
  assign gshift = {8'h00, GLYPH_ROM[slot_q][gcol]} << y_start_q[2:0];

  // Fill band limits within the current page.
  assign lo = at_page_first ? y_start_q[2:0] : 3'd0;
  assign hi = at_page_last ? y_last[2:0] : 3'd7;

  // Bit mask for the current byte.
  always_comb begin
    mask = 8'h00;
    unique case (cmd_q)
      CMD_SET, CMD_UNSET: mask = 8'h01 << y_start_q[2:0];
      CMD_GLYPH:          mask = at_page_first ? gshift[7:0] : gshift[15:8];
      CMD_FILL:           mask = (8'hFF << lo) & (8'hFF >> (3'd7 - hi));
      default:            mask = 8'h00;
    endcase
  end

  assign new_byte = (cmd_q == CMD_UNSET) ? (rdata_q & ~mask) : (rdata_q | mask);

  // Address and clipping of the current byte.
  always_comb begin
    if (cmd_q == CMD_READ) begin
      byte_ok   = int'(read_index_q) < STORE_BYTES;
      walk_addr = AW'(read_index_q);
    end else begin
      byte_ok   = (int'(col_q) < SCREEN_WIDTH) && (int'(page_q) < PAGE_COUNT);
      walk_addr = AW'(int'(page_q) * SCREEN_WIDTH + int'(col_q));
    end
  end

  // Single memory port shared by the sweep and the byte walk.
  assign mem_addr = cmd_i.sweep_write ? sweep_q : walk_addr;
  assign mem_we   = cmd_i.sweep_write ||
                    (cmd_i.rmw_write && byte_ok && (cmd_q != CMD_READ));

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= cmd_i.sweep_write ? 8'h00 : new_byte;
    if (cmd_i.rmw_read) rdata_q <= mem_q[mem_addr];
  end

  // Request capture and walk cursor advance.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cmd_q        <= cmd_code_e'(command_i);
      x_start_q    <= x_start_i;
      y_start_q    <= y_start_i;
      x_end_q      <= x_end_i;
      y_end_q      <= y_end_i;
      slot_q       <= glyph_slot(char_code_i);
      read_index_q <= read_index_i;
      col_q        <= {1'b0, x_start_i};
      page_q       <= 6'(y_start_i[7:3]);
      acc_q        <= 8'h00;
    end else begin
      if (cmd_i.walk_step) begin
        if (at_page_last) begin
          page_q <= page_first;
          col_q  <= col_q + 9'd1;
        end else begin
          page_q <= page_q + 6'd1;
        end
      end
      if (cmd_i.rmw_write && (cmd_q == CMD_READ)) begin
        acc_q <= byte_ok ? rdata_q : 8'h00;
      end
    end
  end

  // Sweep cursor for the reset pass and the clear command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_write) begin
      sweep_q <= st_o.sweep_last ? '0 : sweep_q + AW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) read_data_q <= acc_q;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

  // Status toward the controller.
  always_comb begin
    st_o            = '0;
    st_o.in_clear   = (command_i == CMD_CLEAR);
    st_o.skip       = ((cmd_q == CMD_FILL) && fill_empty) ||
                      !((cmd_q == CMD_SET) || (cmd_q == CMD_UNSET) ||
                        (cmd_q == CMD_GLYPH) || (cmd_q == CMD_FILL) ||
                        (cmd_q == CMD_READ));
    st_o.walk_last  = walk_last;
    st_o.sweep_last = (sweep_q == AW'(STORE_BYTES - 1));
    st_o.out_full   = out_valid_q && out_stall_i;
  end

endmodule
